// File: hw/rtl/iqws_pkg.sv
// Shared types, constants and the quarter-wave cosine table builder for the
// I/Q waveform synthesizer and mixer. No dependencies.
`default_nettype none

package iqws_pkg;

  // Sizes
  localparam int PHASE_BITS     = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 15;
  localparam int U_BITS         = 16;
  localparam int AMP_BITS       = 15;
  localparam int ROM_BITS       = 15;
  localparam int STEP_BITS      = 32;
  localparam int OFFSET_BITS    = 16;
  localparam int COS_DEPTH      = 1024;
  localparam int COS_ADDR_BITS  = $clog2(COS_DEPTH);
  localparam int ROM_IDX_BITS   = COS_ADDR_BITS + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Quarter cycle in top-of-phase units
  localparam logic [U_BITS-1:0] QUARTER = U_BITS'(1 << (U_BITS - 2));

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SHAPE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMBINE_MODE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUADRATURE_ON = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE     = 3'd5;

  // Combine modes
  localparam logic COMBINE_ADD = 1'b0;
  localparam logic COMBINE_MIX = 1'b1;

  typedef enum logic [1:0] {
    WAVE_COS,
    WAVE_SAW,
    WAVE_TRI,
    WAVE_SQUARE
  } wave_shape_t;

  typedef struct packed {
    wave_shape_t            wave_shape;
    logic                   combine_mode;
    logic                   quadrature_on;
    logic [STEP_BITS-1:0]   phase_step;
    logic [OFFSET_BITS-1:0] phase_offset;
    logic [AMP_BITS-1:0]    amplitude;
  } cfg_t;

  // One accepted sample with its phase already resolved
  typedef struct packed {
    logic [U_BITS-1:0]             phase;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCALE,
    B_SHAPE,
    B_MIX,
    B_OUT
  } back_state_t;

  typedef logic [ROM_BITS-1:0] cos_rom_t [0:COS_DEPTH];

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint          Q30One    = 64'sd1 << 30;
  localparam longint unsigned RomScale  = 64'd32767;
  localparam longint unsigned SeriesDiv [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                  64'd90, 64'd132, 64'd182};

  // Quarter-wave cosine, Q30 Taylor series, rounded to Q15; elaboration only
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t          rom;
    longint unsigned   y;
    longint unsigned   y2;
    longint unsigned   p;
    longint            t;
    longint unsigned   q;
    for (int i = 0; i <= COS_DEPTH; i++) begin
      y  = (HalfPiQ30 * longint'(i)) / COS_DEPTH;
      y2 = (y * y) >> 30;
      t  = Q30One;
      for (int k = 7; k >= 1; k--) begin
        p = (y2 * longint'(t)) >> 30;
        t = Q30One - longint'(p / SeriesDiv[k]);
        if (t < 0) begin
          t = 0;
        end
      end
      if (t > Q30One) begin
        t = Q30One;
      end
      q      = (longint'(t) * RomScale + (64'd1 << 29)) >> 30;
      rom[i] = ROM_BITS'(q);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/iqws_queue.sv
// Short queue of resolved items between the front and back parts.
// Depends on iqws_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module iqws_queue
  import iqws_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire item_t wdata,
  output logic       full,
  input  wire logic  rd,
  output item_t      rdata,
  output logic       empty
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/iqws_front.sv
// Front part: accepts input samples, resolves each one's phase from the
// accumulator and offset, and advances or clears the accumulator.
// Depends on iqws_pkg (cfg_t, item_t, sizes).
`default_nettype none

module iqws_front
  import iqws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          push,
  input  wire logic signed [SAMPLE_BITS-1:0] in_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_im,
  input  wire logic                          last_sample,
  input  wire logic                          q_full,
  output logic                               q_wr,
  output item_t                              q_item
);

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_acc_next;

  assign q_wr = push && !q_full;

  // Top phase bits plus offset, wrapping
  always_comb begin
    q_item.phase = phase_acc[PHASE_BITS-1 -: U_BITS] + U_BITS'(cfg.phase_offset);
    q_item.re    = in_re;
    q_item.im    = in_im;
    q_item.last  = last_sample;
  end

  // Clear after a last sample, otherwise advance
  always_comb begin
    if (last_sample) begin
      phase_acc_next = '0;
    end else begin
      phase_acc_next = phase_acc + PHASE_BITS'(cfg.phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (q_wr) begin
      phase_acc <= phase_acc_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/iqws_back.sv
// Back part: looks up the cosine table, scales and shapes the generated
// sample, combines it with the input sample and holds the result register.
// Depends on iqws_pkg (types, sizes, cosine table builder).
`default_nettype none

module iqws_back
  import iqws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          q_empty,
  input  wire item_t                         q_head,
  output logic                               q_rd,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [SAMPLE_BITS-1:0]      out_re,
  output logic signed [SAMPLE_BITS-1:0]      out_im,
  output logic                               last_out
);

  localparam int PROD_BITS = AMP_BITS + U_BITS;
  localparam int MUL_BITS  = 2 * SAMPLE_BITS;
  localparam int WIDE_BITS = 2 * SAMPLE_BITS + 1;
  localparam int G_BITS    = 20;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  localparam logic signed [WIDE_BITS-1:0] SMP_MAX = WIDE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [WIDE_BITS-1:0] SMP_MIN = -SMP_MAX - WIDE_BITS'(1);
  localparam logic signed [WIDE_BITS-1:0] RND_HALF = WIDE_BITS'(1 << (FRAC_BITS - 1));

  back_state_t state;
  back_state_t state_next;
  logic        out_load;
  logic        out_valid;
  logic        out_free;

  item_t                          item;
  logic [U_BITS-1:0]              phase_quad;
  logic [ROM_BITS-1:0]            rom_re;
  logic [ROM_BITS-1:0]            rom_im;
  logic [U_BITS-1:0]              sel_re;
  logic [U_BITS-1:0]              sel_im;
  logic [PROD_BITS-1:0]           mul_re;
  logic [PROD_BITS-1:0]           mul_im;
  logic signed [SAMPLE_BITS-1:0]  g_re;
  logic signed [SAMPLE_BITS-1:0]  g_im;
  logic signed [MUL_BITS-1:0]     p_rr;
  logic signed [MUL_BITS-1:0]     p_ii;
  logic signed [MUL_BITS-1:0]     p_ri;
  logic signed [MUL_BITS-1:0]     p_ir;
  logic signed [WIDE_BITS-1:0]    mix_re;
  logic signed [WIDE_BITS-1:0]    mix_im;
  logic signed [WIDE_BITS-1:0]    sum_re;
  logic signed [WIDE_BITS-1:0]    sum_im;
  logic signed [SAMPLE_BITS-1:0]  res_re;
  logic signed [SAMPLE_BITS-1:0]  res_im;

  // Mirror the index in the second and fourth quadrants
  function automatic logic [ROM_IDX_BITS-1:0] rom_index(logic [U_BITS-1:0] u);
    logic [COS_ADDR_BITS-1:0] r;
    r = u[U_BITS-3 -: COS_ADDR_BITS];
    if (u[U_BITS-2]) begin
      return ROM_IDX_BITS'(COS_DEPTH) - {1'b0, r};
    end
    return {1'b0, r};
  endfunction

  // Turn an amplitude product into the generated sample for one shape
  function automatic logic signed [SAMPLE_BITS-1:0] shape_value(
    wave_shape_t           shape,
    logic [U_BITS-1:0]     u,
    logic [PROD_BITS-1:0]  prod,
    logic [AMP_BITS-1:0]   amp
  );
    logic [PROD_BITS-1:0]     xc;
    logic [U_BITS-1:0]        q0;
    logic [U_BITS:0]          r0;
    logic [U_BITS:0]          m;
    logic [PROD_BITS:0]       saw_sum;
    logic [PROD_BITS:0]       tri_sum;
    logic signed [G_BITS-1:0] a_s;
    logic signed [G_BITS-1:0] s_s;
    logic signed [G_BITS-1:0] v;
    a_s = $signed(G_BITS'(amp));
    v   = '0;
    case (shape)
      WAVE_COS: begin
        // Divide by 32767: 32768 is one more than the divisor
        xc = prod + PROD_BITS'(16383);
        q0 = xc[PROD_BITS-1 -: U_BITS];
        r0 = (U_BITS+1)'(xc[FRAC_BITS-1:0]) + (U_BITS+1)'(q0);
        m  = (U_BITS+1)'(q0);
        if (r0 >= (U_BITS+1)'(65534)) begin
          m = m + (U_BITS+1)'(2);
        end else if (r0 >= (U_BITS+1)'(32767)) begin
          m = m + (U_BITS+1)'(1);
        end
        v = $signed(G_BITS'(m));
        if (u[U_BITS-1] ^ u[U_BITS-2]) begin
          v = -v;
        end
      end
      WAVE_SAW: begin
        saw_sum = (PROD_BITS+1)'(prod) + (PROD_BITS+1)'(16384);
        v = $signed(G_BITS'(saw_sum[PROD_BITS:15])) - a_s;
      end
      WAVE_TRI: begin
        tri_sum = (PROD_BITS+1)'(prod) + (PROD_BITS+1)'(8192);
        s_s = $signed(G_BITS'(tri_sum[PROD_BITS:14]));
        if (u[U_BITS-1]) begin
          v = a_s + a_s + a_s - s_s;
        end else begin
          v = s_s - a_s;
        end
      end
      WAVE_SQUARE: begin
        v = u[U_BITS-1] ? a_s : -a_s;
      end
      default: begin
        v = '0;
      end
    endcase
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(logic signed [WIDE_BITS-1:0] v);
    if (v > SMP_MAX) begin
      return SAMPLE_BITS'(SMP_MAX);
    end
    if (v < SMP_MIN) begin
      return SAMPLE_BITS'(SMP_MIN);
    end
    return SAMPLE_BITS'(v);
  endfunction

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty) state_next = B_SCALE;
      B_SCALE: state_next = B_SHAPE;
      B_SHAPE: state_next = B_MIX;
      B_MIX:   state_next = B_OUT;
      B_OUT:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    q_rd     = 1'b0;
    out_load = 1'b0;
    case (state)
      B_IDLE:  q_rd = !q_empty;
      B_OUT:   out_load = out_free;
      default: begin
        q_rd     = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign phase_quad = item.phase + QUARTER;
  assign sel_re     = (cfg.wave_shape == WAVE_COS) ? U_BITS'(rom_re) : item.phase;
  assign sel_im     = (cfg.wave_shape == WAVE_COS) ? U_BITS'(rom_im) : phase_quad;

  // Take the item and read both table entries
  always_ff @(posedge clk) begin
    if (q_rd) begin
      item   <= q_head;
      rom_re <= COS_ROM[rom_index(q_head.phase)];
      rom_im <= COS_ROM[rom_index(q_head.phase + QUARTER)];
    end
  end

  // Scale by the amplitude
  always_ff @(posedge clk) begin
    if (state == B_SCALE) begin
      mul_re <= PROD_BITS'(cfg.amplitude) * PROD_BITS'(sel_re);
      mul_im <= PROD_BITS'(cfg.amplitude) * PROD_BITS'(sel_im);
    end
  end

  // Shape; the quadrature part is the negated wave a quarter cycle ahead, or zero when off
  always_ff @(posedge clk) begin
    if (state == B_SHAPE) begin
      g_re <= shape_value(cfg.wave_shape, item.phase, mul_re, cfg.amplitude);
      if (cfg.quadrature_on) begin
        g_im <= -shape_value(cfg.wave_shape, phase_quad, mul_im, cfg.amplitude);
      end else begin
        g_im <= '0;
      end
    end
  end

  // Complex products for mixing
  always_ff @(posedge clk) begin
    if (state == B_MIX) begin
      p_rr <= MUL_BITS'(g_re) * MUL_BITS'(item.re);
      p_ii <= MUL_BITS'(g_im) * MUL_BITS'(item.im);
      p_ri <= MUL_BITS'(g_re) * MUL_BITS'(item.im);
      p_ir <= MUL_BITS'(g_im) * MUL_BITS'(item.re);
    end
  end

  // Combine: round and saturate the mix, or saturate the sum
  always_comb begin
    mix_re = WIDE_BITS'(p_rr) - WIDE_BITS'(p_ii);
    mix_im = WIDE_BITS'(p_ri) + WIDE_BITS'(p_ir);
    mix_re = (mix_re + RND_HALF) >>> FRAC_BITS;
    mix_im = (mix_im + RND_HALF) >>> FRAC_BITS;
    sum_re = WIDE_BITS'(item.re) + WIDE_BITS'(g_re);
    sum_im = WIDE_BITS'(item.im) + WIDE_BITS'(g_im);
    if (cfg.combine_mode == COMBINE_MIX) begin
      res_re = sat(mix_re);
      res_im = sat(mix_im);
    end else begin
      res_re = sat(sum_re);
      res_im = sat(sum_im);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re   <= res_re;
      out_im   <= res_im;
      last_out <= item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/iq_waveform_synth_mixer_core.sv
// Top level of the I/Q waveform synthesizer and mixer: configuration
// registers, front part, item queue and back part.
// Depends on iqws_pkg, iqws_front, iqws_queue and iqws_back.
`default_nettype none

// Streaming direct digital synthesizer with I/Q mixing. Samples enter through
// push/full and results leave through empty/pop, one result per sample, in
// order. Each sample is combined with a generated cosine, sawtooth, triangle
// or square sample, by saturating addition or by a rounded Q1.15 complex
// multiply. The front part resolves the phase in the accept cycle and places
// the sample in a two-entry queue; the back part handles one sample at a time
// through table read, amplitude multiply, shaping, mix multiply and
// combine into the result register, waiting there until the previous result
// is popped, and takes no new sample from the queue before then. The cosine
// table is a constant ROM and needs no fill after reset.
// Write configuration only while no sample is in flight.
module iq_waveform_synth_mixer_core
  import iqws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_im,
  input  wire logic                          last_sample,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      out_re,
  output logic signed [SAMPLE_BITS-1:0]      out_im,
  output logic                               last_out,
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  cfg_t  cfg;
  logic  q_wr;
  item_t q_wdata;
  logic  q_full;
  logic  q_rd;
  item_t q_head;
  logic  q_empty;

  assign full = q_full;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_shape    <= WAVE_COS;
      cfg.combine_mode  <= COMBINE_ADD;
      cfg.quadrature_on <= 1'b1;
      cfg.phase_step    <= '0;
      cfg.phase_offset  <= '0;
      cfg.amplitude     <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WAVE_SHAPE:    cfg.wave_shape    <= wave_shape_t'(cfg_data[1:0]);
        REG_COMBINE_MODE:  cfg.combine_mode  <= cfg_data[0];
        REG_QUADRATURE_ON: cfg.quadrature_on <= cfg_data[0];
        REG_PHASE_STEP:    cfg.phase_step    <= cfg_data[STEP_BITS-1:0];
        REG_PHASE_OFFSET:  cfg.phase_offset  <= cfg_data[OFFSET_BITS-1:0];
        REG_AMPLITUDE:     cfg.amplitude     <= cfg_data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  iqws_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .in_re       (in_re),
    .in_im       (in_im),
    .last_sample (last_sample),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_item      (q_wdata)
  );

  iqws_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_head),
    .empty (q_empty)
  );

  iqws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_re   (out_re),
    .out_im   (out_im),
    .last_out (last_out)
  );

endmodule

`default_nettype wire
